FILE: sv/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the LSB-first code bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Largest code accepted per request
    localparam int MAX_CODE_BITS = 64;
    // Bits per emitted byte
    localparam int BYTE_BITS = 8;
    // Depth of the queue between the front and back parts
    localparam int Q_DEPTH = 2;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_command;

    typedef struct packed {
        t_command    command;
        logic [63:0] code_bits;
        logic [6:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Back part sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

endpackage

FILE: sv/lbp_fifo.sv
// ----------------------------------------------------------------------------
// lbp_fifo
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module lbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lbp_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts requests, saturates the length, masks unused code bits and drops
// zero-length appends before they reach the queue.
// ----------------------------------------------------------------------------
module lbp_front #(
    parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS,
    parameter int LW            = $clog2(MAX_CODE_BITS + 1),
    parameter int QW            = 1 + MAX_CODE_BITS + LW
) (
    input  logic             i_push,
    output logic             o_full,
    input  lbp_pkg::t_in_item i_item,
    output logic             o_q_push,
    output logic [QW-1:0]    o_q_data,
    input  logic             i_q_full
);

    logic [6:0]               len_sat;
    logic [MAX_CODE_BITS-1:0] bits_masked;
    logic                     is_flush;
    logic                     drop;

    assign o_full   = i_q_full;
    assign is_flush = (i_item.command == lbp_pkg::CMD_FLUSH);

    // Clamp the length and clear bits at and above it
    always_comb begin
        len_sat = (i_item.code_length > 7'(MAX_CODE_BITS)) ? 7'(MAX_CODE_BITS)
                                                           : i_item.code_length;
        for (int i = 0; i < MAX_CODE_BITS; i++) begin
            bits_masked[i] = i_item.code_bits[i] && (7'(i) < len_sat);
        end
    end

    // Drop appends that carry no bits
    assign drop     = !is_flush && (len_sat == 7'd0);
    assign o_q_push = i_push && !i_q_full && !drop;
    assign o_q_data = {is_flush, bits_masked, len_sat[LW-1:0]};

endmodule

FILE: sv/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Merges queued codes with the pending bits; emits completed bytes into a
// registered output slot, one per cycle while it is free; handles flushes.
// ----------------------------------------------------------------------------
module lbp_back #(
    parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS,
    parameter int LW            = $clog2(MAX_CODE_BITS + 1),
    parameter int QW            = 1 + MAX_CODE_BITS + LW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  logic [QW-1:0]      i_q_data,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output lbp_pkg::t_out_item o_item
);

    localparam int BB = lbp_pkg::BYTE_BITS;
    localparam int WW = MAX_CODE_BITS + BB - 1;
    localparam int RW = $clog2(MAX_CODE_BITS + BB);

    lbp_pkg::t_back_state     r_state, n_state;
    logic [BB-2:0]            r_acc, n_acc;
    logic [2:0]               r_cnt, n_cnt;
    logic [WW-1:0]            r_win, n_win;
    logic [RW-1:0]            r_rem, n_rem;
    logic                     r_out_valid, n_out_valid;
    logic [7:0]               r_out_byte, n_out_byte;
    logic                     r_out_last, n_out_last;

    logic                     q_flush;
    logic [MAX_CODE_BITS-1:0] q_bits;
    logic [LW-1:0]            q_len;
    logic                     slot_free;
    logic [WW-1:0]            win_load;
    logic [RW-1:0]            rem_load;
    logic [WW-1:0]            win_shift;
    logic [RW-1:0]            rem_shift;

    assign {q_flush, q_bits, q_len} = i_q_data;
    assign slot_free = !r_out_valid || i_pop;

    // Align new code bits above the pending ones
    assign win_load  = ({{(BB - 1){1'b0}}, q_bits} << r_cnt) |
                       {{MAX_CODE_BITS{1'b0}}, r_acc};
    assign rem_load  = RW'(q_len) + RW'(r_cnt);
    assign win_shift = r_win >> BB;
    assign rem_shift = r_rem - RW'(BB);

    // Sequence the byte emission and the pending accumulator
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_win       = r_win;
        n_rem       = r_rem;
        n_out_valid = r_out_valid && !i_pop;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        unique case (r_state)
            lbp_pkg::BK_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_pop = 1'b1;
                    if (q_flush) begin
                        if (r_cnt != 3'd0) begin
                            n_out_valid = 1'b1;
                            n_out_byte  = {1'b0, r_acc};
                            n_out_last  = 1'b1;
                        end
                        n_acc = '0;
                        n_cnt = '0;
                    end else if (rem_load < RW'(BB)) begin
                        n_acc = win_load[BB-2:0];
                        n_cnt = rem_load[2:0];
                    end else begin
                        n_win   = win_load;
                        n_rem   = rem_load;
                        n_state = lbp_pkg::BK_EMIT;
                    end
                end
            end
            lbp_pkg::BK_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_win[7:0];
                    n_out_last  = (rem_shift < RW'(BB));
                    n_win       = win_shift;
                    n_rem       = rem_shift;
                    if (rem_shift < RW'(BB)) begin
                        n_acc   = win_shift[BB-2:0];
                        n_cnt   = rem_shift[2:0];
                        n_state = lbp_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = lbp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbp_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold accumulator and output slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_rem      <= n_rem;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_empty         = !r_out_valid;
    assign o_item.out_byte = r_out_byte;
    assign o_item.last     = r_out_last;

endmodule

FILE: sv/lsb_first_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// lsb_first_code_bit_packer_top
// Packs variable-length codes LSB first into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_item and raise push; the request is taken on an edge
//   where full is low. An append request adds the low code_length bits of
//   code_bits (clamped to MAX_CODE_BITS) to the pending bits; a flush request
//   emits the pending partial byte zero padded and clears it.
//   Output queue: while empty is low, o_item holds the oldest byte; raise pop
//   to take it. last marks the final byte produced by one request.
//   Flow: with the back part idle, an append passes the queue, the back
//   part's shift window and the output slot register before its first byte
//   shows on o_item; the byte of a flush goes from the queue to the slot.
//   The back part loads an append in its idle state and then its byte shifter
//   moves out completed bytes one per cycle while the output slot is free; an
//   append that completes no byte, or a flush, needs only the idle state.
//   A two-entry queue lets new requests be taken while bytes are emitted.
//   Reset clears the pending bits, the request queue and the output slot.
//   When the receiver stalls, the output byte holds, the back part waits and
//   full rises once the queue fills.
// ----------------------------------------------------------------------------
module lsb_first_code_bit_packer_top #(
    parameter int MAX_CODE_BITS = lbp_pkg::MAX_CODE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lbp_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output lbp_pkg::t_out_item o_item
);

    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int QW = 1 + MAX_CODE_BITS + LW;

    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_full;
    logic          q_valid;
    logic [QW-1:0] q_rdata;
    logic          q_pop;

    lbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .LW            (LW),
        .QW            (QW)
    ) u_front (
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .o_q_push (q_push),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    lbp_fifo #(
        .WIDTH (QW),
        .DEPTH (lbp_pkg::Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (q_pop)
    );

    lbp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .LW            (LW),
        .QW            (QW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

FILE: sv/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks for the code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module lbp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input lbp_pkg::t_out_item o_item
);

    logic r_seen_req;

    // Remember whether any request has been taken since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_req <= 1'b0;
        end else if (push && !full) begin
            r_seen_req <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_no_invented_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_seen_req)
        else $error("byte shown before any request was taken");

    a_no_early_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> r_seen_req)
        else $error("full raised before any request was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_item))
        else $error("stalled output byte changed");

endmodule

bind lsb_first_code_bit_packer_top lbp_checker u_lbp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

FILE: bench/lsb_first_code_bit_packer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_code_bit_packer_top_test
// Drives append and flush requests into the packer and checks every emitted
// byte and its last flag against a bit-level packing predictor. A directed
// opening covers the corner cases. Random traffic follows, with idle bursts
// on both sides and a pause every DRAIN_EVERY requests that drains the bytes.
// ----------------------------------------------------------------------------
module lsb_first_code_bit_packer_top_test;
    import lbp_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 24;
    localparam int RANDOM_COUNT  = 480;
    localparam int DRAIN_EVERY   = 150;
    localparam int CALM_TAIL     = 60;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_item;

    // Predictor state: bits waiting to fill a byte
    logic [6:0] pend_bits  = '0;
    logic [2:0] pend_count = '0;

    t_in_item  pending_requests[$];
    t_out_item packed_bytes_due[$];
    t_out_item byte_due;

    int unsigned requests_taken = 0;
    int unsigned request_total  = 0;
    int unsigned stall_cycles   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_gap       = 0;
    int unsigned pick;
    bit          drain_hold     = 1'b0;

    lsb_first_code_bit_packer_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_in_item make_request(input t_command cmd, input logic [63:0] bits,
                                              input logic [6:0] len);
        t_in_item req;
        req.command     = cmd;
        req.code_bits   = bits;
        req.code_length = len;
        return req;
    endfunction

    // Idle only outside the calm stretches and the closing part of the run
    function automatic bit idling_allowed();
        return pending_requests.size() > CALM_TAIL && ((requests_taken / 40) % 3 != 2);
    endfunction

    // Append code bits LSB first and queue every completed byte; a flush
    // queues the zero-padded partial byte
    task automatic pack_code_request(input t_in_item req);
        logic [7:0]  acc;
        int unsigned cnt;
        int unsigned len;
        bit          have_prev;
        t_out_item   prev;
        acc       = {1'b0, pend_bits};
        cnt       = pend_count;
        have_prev = 1'b0;
        prev      = '0;
        if (req.command == CMD_FLUSH) begin
            if (cnt != 0) begin
                prev.out_byte = acc;
                prev.last     = 1'b1;
                packed_bytes_due.push_back(prev);
            end
            pend_bits  = '0;
            pend_count = '0;
        end else begin
            len = (req.code_length > MAX_CODE_BITS) ? MAX_CODE_BITS : req.code_length;
            for (int i = 0; i < len; i++) begin
                acc[cnt] = req.code_bits[i];
                cnt++;
                if (cnt == BYTE_BITS) begin
                    // hold each byte back one step so the final one gets last
                    if (have_prev) packed_bytes_due.push_back(prev);
                    prev.out_byte = acc;
                    prev.last     = 1'b0;
                    have_prev     = 1'b1;
                    acc           = '0;
                    cnt           = 0;
                end
            end
            if (have_prev) begin
                prev.last = 1'b1;
                packed_bytes_due.push_back(prev);
            end
            pend_bits  = acc[6:0];
            pend_count = cnt[2:0];
        end
    endtask

    // Sender: predict on each taken request, then offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (push) begin
                pack_code_request(i_item);
                requests_taken++;
                if (requests_taken % DRAIN_EVERY == 0) drain_hold = 1'b1;
            end
            if (drain_hold && packed_bytes_due.size() == 0) drain_hold = 1'b0;
            if (send_gap == 0 && idling_allowed() && $urandom_range(0, 5) == 0)
                send_gap = $urandom_range(1, 11);
            if (send_gap != 0 || drain_hold || pending_requests.size() == 0) begin
                if (send_gap != 0) send_gap--;
                push <= 1'b0;
            end else begin
                i_item <= pending_requests.pop_front();
                push   <= 1'b1;
            end
        end
    end

    // Receiver: check each popped byte against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (packed_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              o_item.out_byte, o_item.last));
                end else begin
                    byte_due = packed_bytes_due.pop_front();
                    if (o_item.out_byte !== byte_due.out_byte)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  o_item.out_byte, byte_due.out_byte));
                    if (o_item.last !== byte_due.last)
                        report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                                  o_item.last, byte_due.last,
                                                  byte_due.out_byte));
                end
            end
            if (recv_gap == 0 && idling_allowed() && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 11);
            if (recv_gap != 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no request moves on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Directed opening
        pending_requests.push_back(make_request(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
        pending_requests.push_back(make_request(CMD_FLUSH, 64'h0, 7'd0));
        pending_requests.push_back(make_request(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3));
        pending_requests.push_back(make_request(CMD_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
        pending_requests.push_back(make_request(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h0000_0000_0000_007F, 7'd7));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h8000_0000_0000_0001, 7'd64));
        pending_requests.push_back(make_request(CMD_FLUSH, 64'h0, 7'd0));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h0123_4567_89AB_CDEF, 7'd127));
        pending_requests.push_back(make_request(CMD_APPEND, 64'hFEDC_BA98_7654_3210, 7'd65));
        pending_requests.push_back(make_request(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd5));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h0, 7'd3));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h0, 7'd64));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h0, 7'd8));
        for (int i = 0; i < 8; i++)
            pending_requests.push_back(make_request(CMD_APPEND, {63'h0, i[0]}, 7'd1));
        pending_requests.push_back(make_request(CMD_APPEND, 64'h5555_5555_5555_5555, 7'd13));
        pending_requests.push_back(make_request(CMD_FLUSH, 64'hAAAA_AAAA_AAAA_AAAA, 7'd64));

        // Random: mostly short codes, some full or out-of-range, some flushes
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                pending_requests.push_back(make_request(CMD_FLUSH, {$urandom, $urandom},
                                                        7'($urandom)));
            else if (pick == 2)
                pending_requests.push_back(make_request(CMD_APPEND, {$urandom, $urandom},
                                                        7'($urandom_range(0, 127))));
            else if (pick == 3)
                pending_requests.push_back(make_request(CMD_APPEND, {$urandom, $urandom},
                                                        7'd64));
            else
                pending_requests.push_back(make_request(CMD_APPEND, {$urandom, $urandom},
                                                        7'($urandom_range(1, 16))));
        end
        request_total = pending_requests.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken != request_total && stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        while (packed_bytes_due.size() != 0 && stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (stall_cycles >= STALL_LIMIT)
            report_mismatch("timeout: no request moved");
        if (packed_bytes_due.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came",
                                      packed_bytes_due.size()));
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: lsb_first_code_bit_packer_top.f
sv/lbp_pkg.sv
sv/lbp_fifo.sv
sv/lbp_front.sv
sv/lbp_back.sv
sv/lsb_first_code_bit_packer_top.sv
sv/lbp_checker.sv
bench/lsb_first_code_bit_packer_top_test.sv
